// ===== hdl/tcws_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tcws_pkg;

  // Glyph cell and font geometry
  localparam int GLYPH_WIDTH      = 8;
  localparam int GLYPH_HEIGHT     = 16;
  localparam int FIRST_GLYPH_CODE = 32;
  localparam int GLYPH_COUNT      = 96;
  localparam int COORD_BITS       = 12;

  // Fixed field widths on the channels
  localparam int POS_W   = 12;
  localparam int DIM_W   = 12;
  localparam int CODE_W  = 8;
  localparam int GLYPH_W = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  // Result queue depth (power of two, at least 2)
  localparam int QDEPTH = 4;

  // Control characters
  localparam logic [CODE_W-1:0] CODE_NUL     = 8'd0;
  localparam logic [CODE_W-1:0] CODE_NEWLINE = 8'd10;
  localparam logic [CODE_W-1:0] CODE_RETURN  = 8'd13;

  // Result kinds
  localparam logic KIND_DRAW   = 1'b0;
  localparam logic KIND_SCROLL = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_ENABLED = 2'd2;

  localparam logic [DIM_W-1:0] SCREEN_WIDTH_RST  = 12'd640;
  localparam logic [DIM_W-1:0] SCREEN_HEIGHT_RST = 12'd480;

  typedef struct packed {
    logic [DIM_W-1:0] screen_width;
    logic [DIM_W-1:0] screen_height;
    logic             display_enabled;
  } cfg_t;

  typedef struct packed {
    logic               result_kind;
    logic [POS_W-1:0]   pos_x;
    logic [POS_W-1:0]   pos_y;
    logic [GLYPH_W-1:0] glyph_index;
    logic               last_of_run;
  } result_t;

  // Up to two results handed to the queue in one cycle, in order
  typedef struct packed {
    logic [1:0] cnt;
    result_t    res0;
    result_t    res1;
  } push_t;

endpackage

`default_nettype wire

// ===== hdl/tcws_ifs.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface tcws_in_if;
  logic        valid;
  logic        ready;
  logic        start_of_string;
  logic [11:0] origin_x;
  logic [11:0] origin_y;
  logic [7:0]  char_code;

  modport source (output valid, start_of_string, origin_x, origin_y, char_code,
                  input ready);
  modport sink   (input valid, start_of_string, origin_x, origin_y, char_code,
                  output ready);
endinterface

interface tcws_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [11:0] pos_x;
  logic [11:0] pos_y;
  logic [6:0]  glyph_index;
  logic        last_of_run;

  modport source (output valid, result_kind, pos_x, pos_y, glyph_index, last_of_run,
                  input ready);
  modport sink   (input valid, result_kind, pos_x, pos_y, glyph_index, last_of_run,
                  output ready);
endinterface

interface tcws_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [11:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hdl/tcws_cursor.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tcws_cursor #(
  parameter int COORD_BITS = tcws_pkg::COORD_BITS
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic                         in_start,
  input  wire logic [tcws_pkg::POS_W-1:0]   in_origin_x,
  input  wire logic [tcws_pkg::POS_W-1:0]   in_origin_y,
  input  wire logic [tcws_pkg::CODE_W-1:0]  in_code,
  input  wire tcws_pkg::cfg_t               cfg,
  input  wire logic                         space_ok,
  output tcws_pkg::push_t                   push
);
  import tcws_pkg::*;

  localparam int BASE_W = (COORD_BITS > DIM_W) ? COORD_BITS : DIM_W;
  localparam int SUM_W  = BASE_W + 8;

  // input word register
  logic                  s1_v_r, s1_v_nxt;
  logic                  s1_start_r;
  logic [POS_W-1:0]      s1_ox_r, s1_oy_r;
  logic [CODE_W-1:0]     s1_code_r;

  // cursor state
  logic [COORD_BITS-1:0] cx_r, cy_r, lm_r;
  logic [COORD_BITS-1:0] cx_nxt, cy_nxt, lm_nxt;

  logic                  fire, load;
  logic [COORD_BITS-1:0] cx0, cy0, lm0;
  logic [SUM_W-1:0]      cx_w, cy_w, sw_w, sh_w, gw_w, gh_w;
  logic [SUM_W-1:0]      nx_w, ny_w;
  logic [9:0]            code_w, off_w;
  logic                  fits, in_font, draw, wrap, adv, scroll;
  result_t               r_draw, r_scroll;

  assign fire     = s1_v_r && space_ok;
  assign in_ready = !s1_v_r || space_ok;
  assign load     = in_valid && in_ready;
  assign s1_v_nxt = load ? 1'b1 : (fire ? 1'b0 : s1_v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_start_r <= in_start;
      s1_ox_r    <= in_origin_x;
      s1_oy_r    <= in_origin_y;
      s1_code_r  <= in_code;
    end
  end

  always_comb begin
    cx0 = s1_start_r ? COORD_BITS'(s1_ox_r) : cx_r;
    lm0 = s1_start_r ? COORD_BITS'(s1_ox_r) : lm_r;
    cy0 = s1_start_r ? COORD_BITS'(s1_oy_r) : cy_r;

    cx_w = SUM_W'(cx0);
    cy_w = SUM_W'(cy0);
    sw_w = SUM_W'(cfg.screen_width);
    sh_w = SUM_W'(cfg.screen_height);
    gw_w = SUM_W'(GLYPH_WIDTH);
    gh_w = SUM_W'(GLYPH_HEIGHT);
    nx_w = cx_w + gw_w;
    ny_w = cy_w + gh_w;

    code_w  = 10'(s1_code_r);
    off_w   = code_w - 10'(FIRST_GLYPH_CODE);
    fits    = (nx_w <= sw_w) && (ny_w <= sh_w);
    in_font = (code_w >= 10'(FIRST_GLYPH_CODE)) && (off_w < 10'(GLYPH_COUNT));
    wrap    = (nx_w + gw_w) > sw_w;
    scroll  = (ny_w + gh_w) > sh_w;

    draw = 1'b0;
    adv  = 1'b0;
    cx_nxt = cx0;
    cy_nxt = cy0;
    lm_nxt = lm0;

    if (s1_code_r == CODE_NEWLINE) begin
      cx_nxt = lm0;
      adv    = 1'b1;
    end else if (s1_code_r == CODE_RETURN) begin
      cx_nxt = lm0;
    end else if (s1_code_r != CODE_NUL) begin
      draw = fits && in_font;
      if (wrap) begin
        cx_nxt = lm0;
        adv    = 1'b1;
      end else begin
        cx_nxt = nx_w[COORD_BITS-1:0];
      end
    end

    // past the bottom the row stays where it was
    if (adv && !scroll) begin
      cy_nxt = ny_w[COORD_BITS-1:0];
    end

    r_draw.result_kind = KIND_DRAW;
    r_draw.pos_x       = POS_W'(cx0);
    r_draw.pos_y       = POS_W'(cy0);
    r_draw.glyph_index = off_w[GLYPH_W-1:0];
    r_draw.last_of_run = !(adv && scroll);

    r_scroll.result_kind = KIND_SCROLL;
    r_scroll.pos_x       = '0;
    r_scroll.pos_y       = '0;
    r_scroll.glyph_index = '0;
    r_scroll.last_of_run = 1'b1;

    push.res0 = draw ? r_draw : r_scroll;
    push.res1 = r_scroll;
    push.cnt  = 2'(draw) + 2'(adv && scroll);
    if (!fire || !cfg.display_enabled) begin
      push.cnt = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r <= '0;
      cy_r <= '0;
      lm_r <= '0;
    end else if (fire && cfg.display_enabled) begin
      cx_r <= cx_nxt;
      cy_r <= cy_nxt;
      lm_r <= lm_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/tcws_res_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tcws_res_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire tcws_pkg::push_t   push,
  output logic                   space_ok,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output tcws_pkg::result_t      out_res
);
  import tcws_pkg::*;

  localparam int PTR_W = $clog2(QDEPTH);
  localparam int CNT_W = PTR_W + 1;

  result_t           mem_r [QDEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              pop;

  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid && out_ready;
  assign out_res   = mem_r[rd_ptr_r];
  assign space_ok  = (cnt_r <= CNT_W'(QDEPTH - 2));

  assign wr_ptr_nxt = wr_ptr_r + PTR_W'(push.cnt);
  assign rd_ptr_nxt = rd_ptr_r + PTR_W'(pop);
  assign cnt_nxt    = cnt_r + CNT_W'(push.cnt) - CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (push.cnt)
      2'd1: begin
        mem_r[wr_ptr_r] <= push.res0;
      end
      2'd2: begin
        mem_r[wr_ptr_r]               <= push.res0;
        mem_r[wr_ptr_r + PTR_W'(1)]   <= push.res1;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/text_cursor_wrap_scroll.sv =====
// Text console cursor: turns a stream of character codes into draw-glyph and
// scroll commands for a pixel framebuffer.
// in_if  : one character word per handshake (start flag, origin, code).
// out_if : command words; a character gives zero, one or two (draw, then
//          scroll), last_of_run marks the final word of a character.
// cfg_if : register writes (screen width, height, display enable), always
//          ready; write only while the block is idle.
// Path: a taken word sits in the input register, is worked out and written
// into the result queue once it has room, then shows on out_if from there.
// Throughput: one character per cycle while the queue has room, set by the
// single cursor update between input register and result queue; two-command
// characters are limited by the output side at one command per cycle.
// Reset (rst_n low, synchronous) zeroes cursor and margin, empties the queue
// and loads width 640, height 480, display disabled.
// When the receiver stalls, commands collect in a 4-word queue; in_ready
// drops once fewer than two slots are free, so nothing is lost.
`timescale 1ns / 1ps
`default_nettype none

module text_cursor_wrap_scroll #(
  parameter int COORD_BITS = tcws_pkg::COORD_BITS
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  tcws_in_if.sink     in_if,
  tcws_out_if.source  out_if,
  tcws_cfg_if.sink    cfg_if
);
  import tcws_pkg::*;

  cfg_t     cfg_r;
  logic     space_ok;
  push_t    push;
  result_t  out_res;

  // register file
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.screen_width    <= SCREEN_WIDTH_RST;
      cfg_r.screen_height   <= SCREEN_HEIGHT_RST;
      cfg_r.display_enabled <= 1'b0;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.index)
        REG_SCREEN_WIDTH:    cfg_r.screen_width    <= cfg_if.data;
        REG_SCREEN_HEIGHT:   cfg_r.screen_height   <= cfg_if.data;
        REG_DISPLAY_ENABLED: cfg_r.display_enabled <= cfg_if.data[0];
        default: begin
        end
      endcase
    end
  end

  // cursor update and command generation
  tcws_cursor #(
    .COORD_BITS (COORD_BITS)
  ) u_cursor (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_if.valid),
    .in_ready    (in_if.ready),
    .in_start    (in_if.start_of_string),
    .in_origin_x (in_if.origin_x),
    .in_origin_y (in_if.origin_y),
    .in_code     (in_if.char_code),
    .cfg         (cfg_r),
    .space_ok    (space_ok),
    .push        (push)
  );

  // command queue toward the receiver
  tcws_res_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .space_ok  (space_ok),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .out_res   (out_res)
  );

  assign out_if.result_kind = out_res.result_kind;
  assign out_if.pos_x       = out_res.pos_x;
  assign out_if.pos_y       = out_res.pos_y;
  assign out_if.glyph_index = out_res.glyph_index;
  assign out_if.last_of_run = out_res.last_of_run;

endmodule

`default_nettype wire
